### design/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// BMP decoder package
// Shared constants, status codes and the result type of the BMP decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Largest image accepted, in pixels.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Column and row counters must hold the dimension itself.
  localparam int unsigned COL_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 1);

  localparam int unsigned IDX_W = 24;

  localparam logic [15:0] MAGIC_BM   = 16'h4D42;
  localparam logic [31:0] MIN_OFFSET = 32'd54;
  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [15:0] DEPTH_32   = 16'd32;

  // Result status codes.
  localparam logic [1:0] ST_PIXEL     = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

  typedef struct packed {
    logic             last_pixel;
    logic             has_alpha;
    logic [7:0]       alpha;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [IDX_W-1:0] pixel_index;
    logic [1:0]       status;
  } res_t;

endpackage

### design/bmpd_core.sv
// ----------------------------------------------------------------------------
// BMP decoder core
// Parses header bytes, skips to the pixel data and assembles pixels.
// ----------------------------------------------------------------------------
module bmpd_core
  import bmpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       start_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_PIXELS = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [31:0]      pos_q, pos_d;
  logic [31:0]      offset_q, offset_d;
  logic [31:0]      width_q, width_d;
  logic [31:0]      height_q, height_d;
  logic             alpha_en_q, alpha_en_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [1:0]       bip_q, bip_d;
  logic [1:0]       pad_q, pad_d;
  logic [23:0]      chan_q, chan_d;
  logic [IDX_W-1:0] base_q, base_d;

  // Values after an optional restart; the byte is then processed from these.
  logic [1:0]       c_phase;
  logic [31:0]      c_pos, c_offset, c_width, c_height;
  logic             c_alpha_en;
  logic [ROW_W-1:0] c_row;
  logic [COL_W-1:0] c_col;
  logic [1:0]       c_bip, c_pad;
  logic [23:0]      c_chan;
  logic [IDX_W-1:0] c_base;

  logic [ROW_W+COL_W-1:0] base_prod;
  logic [15:0]            depth_bits;
  logic [COL_W-1:0]       col_inc;
  logic [ROW_W-1:0]       row_inc;
  logic [1:0]             hdr_lane;
  logic                   do_pixel;

  always_comb begin
    if (start_i) begin
      c_phase = PH_HEADER; c_pos = '0; c_offset = '0; c_width = '0; c_height = '0;
      c_alpha_en = 1'b0; c_row = '0; c_col = '0; c_bip = '0; c_pad = '0;
      c_chan = '0; c_base = '0;
    end else begin
      c_phase = phase_q; c_pos = pos_q; c_offset = offset_q; c_width = width_q;
      c_height = height_q; c_alpha_en = alpha_en_q; c_row = row_q; c_col = col_q;
      c_bip = bip_q; c_pad = pad_q; c_chan = chan_q; c_base = base_q;
    end
  end

  assign base_prod  = (c_height[ROW_W-1:0] - ROW_W'(1)) * c_width[COL_W-1:0];
  assign depth_bits = {byte_i, c_chan[7:0]};
  assign col_inc    = c_col + COL_W'(1);
  assign row_inc    = c_row + ROW_W'(1);
  // Every 32-bit header field starts at a position that is 2 mod 4.
  assign hdr_lane   = c_pos[1:0] - 2'd2;

  always_comb begin
    phase_d = c_phase; pos_d = c_pos; offset_d = c_offset; width_d = c_width;
    height_d = c_height; alpha_en_d = c_alpha_en; row_d = c_row; col_d = c_col;
    bip_d = c_bip; pad_d = c_pad; chan_d = c_chan; base_d = c_base;
    res_valid_o = 1'b0;
    res_o       = '0;
    do_pixel    = 1'b0;

    unique case (c_phase)
      PH_HEADER: begin
        pos_d = c_pos + 32'd1;
        if (c_pos == 32'd0) begin
          chan_d[7:0] = byte_i;
        end else if (c_pos == 32'd1) begin
          chan_d = '0;
          if ({byte_i, c_chan[7:0]} != MAGIC_BM) begin
            res_valid_o = 1'b1;
            res_o.status = ST_BAD_MAGIC;
            phase_d = PH_IDLE;
          end
        end else if (c_pos >= 32'd10 && c_pos <= 32'd13) begin
          offset_d[8*hdr_lane+:8] = byte_i;
        end else if (c_pos >= 32'd18 && c_pos <= 32'd21) begin
          width_d[8*hdr_lane+:8] = byte_i;
        end else if (c_pos >= 32'd22 && c_pos <= 32'd25) begin
          height_d[8*hdr_lane+:8] = byte_i;
        end else if (c_pos == 32'd28) begin
          chan_d[7:0] = byte_i;
        end else if (c_pos == 32'd29) begin
          chan_d = '0;
          if (depth_bits != DEPTH_24 && depth_bits != DEPTH_32) begin
            res_valid_o = 1'b1;
            res_o.status = ST_BAD_DEPTH;
            phase_d = PH_IDLE;
          end else if (c_width == 32'd0 || c_width > 32'(MAX_WIDTH) ||
                       c_height == 32'd0 || c_height > 32'(MAX_HEIGHT) ||
                       c_offset < MIN_OFFSET) begin
            res_valid_o = 1'b1;
            res_o.status = ST_BAD_SIZE;
            phase_d = PH_IDLE;
          end else begin
            alpha_en_d = (depth_bits == DEPTH_32);
            base_d     = IDX_W'(base_prod);
            phase_d    = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (c_pos != c_offset) begin
          pos_d = c_pos + 32'd1;
        end else begin
          phase_d  = PH_PIXELS;
          do_pixel = 1'b1;
        end
      end
      PH_PIXELS: do_pixel = 1'b1;
      default: ;
    endcase

    if (do_pixel) begin
      if (c_pad != 2'd0) begin
        pad_d = c_pad - 2'd1;
      end else if (c_bip != 2'd3 && !(c_bip == 2'd2 && !c_alpha_en)) begin
        // Still collecting channel bytes of this pixel.
        chan_d[8*c_bip+:8] = byte_i;
        bip_d = c_bip + 2'd1;
      end else begin
        res_valid_o       = 1'b1;
        res_o.status      = ST_PIXEL;
        res_o.pixel_index = c_base + IDX_W'(c_col);
        res_o.red         = c_alpha_en ? c_chan[23:16] : byte_i;
        res_o.green       = c_chan[15:8];
        res_o.blue        = c_chan[7:0];
        res_o.alpha       = c_alpha_en ? byte_i : 8'd0;
        res_o.has_alpha   = c_alpha_en;
        res_o.last_pixel  = (col_inc == c_width[COL_W-1:0]) &&
                            (row_inc == c_height[ROW_W-1:0]);
        chan_d = '0;
        bip_d  = '0;
        col_d  = col_inc;
        if (col_inc == c_width[COL_W-1:0]) begin
          col_d = '0;
          row_d = row_inc;
          if (row_inc == c_height[ROW_W-1:0]) begin
            phase_d = PH_IDLE;
          end else begin
            // Row pitch padding for 24-bit pixels equals width mod 4.
            pad_d  = c_alpha_en ? 2'd0 : c_width[1:0];
            base_d = c_base - IDX_W'(c_width);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; pos_q <= '0; offset_q <= '0; width_q <= '0;
      height_q <= '0; alpha_en_q <= 1'b0; row_q <= '0; col_q <= '0;
      bip_q <= '0; pad_q <= '0; chan_q <= '0; base_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d; pos_q <= pos_d; offset_q <= offset_d; width_q <= width_d;
      height_q <= height_d; alpha_en_q <= alpha_en_d; row_q <= row_d; col_q <= col_d;
      bip_q <= bip_d; pad_q <= pad_d; chan_q <= chan_d; base_q <= base_d;
    end
  end

endmodule

### design/bmpd_out_buf.sv
// ----------------------------------------------------------------------------
// BMP decoder output buffer
// Output register with a skid stage; space_o is low only while the skid is full.
// ----------------------------------------------------------------------------
module bmpd_out_buf
  import bmpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic space_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic drain;

  assign drain   = !out_valid_q || ready_i;
  assign space_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (drain) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (push_i) begin
      skid_q <= res_i;
    end
  end

endmodule

### design/bmp_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// BMP pixel stream decoder
// Decodes an uncompressed 24- or 32-bit BMP file, one byte per beat, into
// one beat per pixel carrying raw channels and a flipped destination index.
// ----------------------------------------------------------------------------
// The slave channel takes one file byte per beat in s_axis_tdata; tuser set
// marks the first byte of a file and restarts parsing from any state. The
// master channel gives one beat per pixel, and one beat with a nonzero status
// in tuser for a bad magic number, an unsupported depth, or a bad size or
// offset. tlast flags the final pixel of the image. After an error or the
// last pixel, bytes are dropped until the next start beat.
// A byte is accepted on every cycle in which s_axis_tvalid and s_axis_tready
// are both high; its result is registered in the output or skid stage. The
// sustained rate is one byte per clock while s_axis_tready stays high, set
// by the single parse stage that updates the header and pixel counters. The
// output register is backed by a one-entry skid stage, so s_axis_tready only
// drops after the receiver has stalled while two results were pending; it
// rises again once one drains. Reset clears the parser to idle and empties
// the output stage; the block then waits for a start beat.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder
  import bmpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [23:0] pixel_index, [31:24] red,
                                      // [39:32] green, [47:40] blue,
                                      // [55:48] alpha
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] has_alpha
  output logic        m_axis_tlast    // last_pixel
);

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;

  // A byte is taken whenever one is offered and the skid stage has room for its result.
  assign accept = s_axis_tvalid && s_axis_tready;

  bmpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .start_i     (s_axis_tuser),
    .byte_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmpd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && res_valid),
    .res_i   (res),
    .space_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.alpha, out_res.blue, out_res.green, out_res.red,
                         out_res.pixel_index};
  assign m_axis_tuser = {out_res.has_alpha, out_res.status};
  assign m_axis_tlast = out_res.last_pixel;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP pixel stream decoder testbench
// Streams BMP files byte by byte into the decoder. A table of directed files
// covers every status code, the size limits and restarts in each parse stage.
// Random files follow under three idle patterns. Every pixel and status beat
// is compared field by field against a predictor that tracks the parser.
// ----------------------------------------------------------------------------
module testbench;
  import bmpd_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_BYTES  = 100;   // per idle pattern
  localparam int N_CASES       = 26;

  // Parse stages of the predictor.
  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_HEADER,
    PARSE_SKIP,
    PARSE_PIXELS
  } parse_stage_e;

  // One directed file. A file without a start on its first byte is plain
  // noise. When status_typed is set, the one beat the file causes is the
  // typed status with all other fields zero.
  typedef struct packed {
    logic        first_start;
    logic [15:0] magic;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] depth;
    logic [31:0] byte_cap;     // 0: whole image plus a few trailing bytes
    logic        status_typed;
    logic [1:0]  status;
  } bmp_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] data_byte
  logic        s_axis_tuser;    // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;    // [23:0] pixel_index, [31:24] red,
                                // [39:32] green, [47:40] blue, [55:48] alpha
  logic [2:0]  m_axis_tuser;    // [1:0] status, [2] has_alpha
  logic        m_axis_tlast;    // last_pixel

  bmp_pixel_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  res_t        pending_results [$];
  int          fail_count    = 0;
  int          cycle_count   = 0;
  int          bytes_sent    = 0;
  int          send_gap_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_request  = 1'b0;
  bit          typed_on      = 1'b0;
  logic [1:0]  typed_status  = ST_PIXEL;
  bmp_case_t   dir_cases [N_CASES];

  // Predictor state, initially clear and cleared again by every start beat.
  parse_stage_e exp_stage  = PARSE_IDLE;
  logic [31:0]  exp_pos    = '0;
  logic [31:0]  exp_offset = '0;
  logic [31:0]  exp_width  = '0;
  logic [31:0]  exp_height = '0;
  logic [31:0]  exp_row    = '0;
  logic [31:0]  exp_col    = '0;
  logic [2:0]   exp_bpp    = '0;
  logic [1:0]   exp_lane   = '0;
  logic [1:0]   exp_pad    = '0;
  logic [23:0]  exp_chan   = '0;
  logic [23:0]  exp_base   = '0;

  // Advance the predictor by one accepted byte; emits is set when the byte
  // completes a pixel or raises an error.
  task automatic decode_byte(input logic start, input logic [7:0] b,
                             output bit emits, output res_t res);
    logic [15:0] depth_bits;
    logic [7:0]  alpha_byte;
    logic [1:0]  err_code;
    bit          failed;
    emits      = 1'b0;
    res        = '0;
    alpha_byte = '0;
    failed     = 1'b0;
    err_code   = ST_PIXEL;
    if (start) begin
      exp_stage  = PARSE_HEADER;
      exp_pos    = '0;
      exp_offset = '0;
      exp_width  = '0;
      exp_height = '0;
      exp_row    = '0;
      exp_col    = '0;
      exp_bpp    = '0;
      exp_lane   = '0;
      exp_pad    = '0;
      exp_chan   = '0;
      exp_base   = '0;
    end
    // The byte at the pixel offset is already the first pixel byte.
    if (exp_stage == PARSE_SKIP && exp_pos == exp_offset) exp_stage = PARSE_PIXELS;
    case (exp_stage)
      PARSE_HEADER: begin
        if (exp_pos == 0) begin
          exp_chan = {16'h0, b};
        end else if (exp_pos == 1) begin
          if ({b, exp_chan[7:0]} != MAGIC_BM || exp_chan[23:8] != 0) begin
            failed   = 1'b1;
            err_code = ST_BAD_MAGIC;
          end
          exp_chan = '0;
        end else if (exp_pos >= 10 && exp_pos <= 13) begin
          exp_offset[8*(exp_pos-10) +: 8] = b;
        end else if (exp_pos >= 18 && exp_pos <= 21) begin
          exp_width[8*(exp_pos-18) +: 8] = b;
        end else if (exp_pos >= 22 && exp_pos <= 25) begin
          exp_height[8*(exp_pos-22) +: 8] = b;
        end else if (exp_pos == 28) begin
          exp_chan = {16'h0, b};
        end else if (exp_pos == 29) begin
          depth_bits = {b, exp_chan[7:0]};
          exp_chan   = '0;
          // Depth is judged before size and offset.
          if (depth_bits != DEPTH_24 && depth_bits != DEPTH_32) begin
            failed   = 1'b1;
            err_code = ST_BAD_DEPTH;
          end else if (exp_width == 0 || exp_width > MAX_WIDTH ||
                       exp_height == 0 || exp_height > MAX_HEIGHT ||
                       exp_offset < MIN_OFFSET) begin
            failed   = 1'b1;
            err_code = ST_BAD_SIZE;
          end else begin
            exp_bpp   = 3'(depth_bits / 8);
            exp_base  = 24'((exp_height - 1) * exp_width);
            exp_stage = PARSE_SKIP;
          end
        end
        if (failed) begin
          emits      = 1'b1;
          res.status = err_code;
          exp_stage  = PARSE_IDLE;
        end else begin
          exp_pos = exp_pos + 1;
        end
      end
      PARSE_SKIP: exp_pos = exp_pos + 1;
      PARSE_PIXELS: begin
        if (exp_pad != 0) begin
          exp_pad = exp_pad - 2'd1;
        end else begin
          if (exp_lane < 3) exp_chan[8*exp_lane +: 8] = b;
          else alpha_byte = b;
          if (int'(exp_lane) + 1 < int'(exp_bpp)) begin
            exp_lane = exp_lane + 2'd1;
          end else begin
            emits           = 1'b1;
            res.status      = ST_PIXEL;
            res.pixel_index = exp_base + exp_col[23:0];
            res.red         = exp_chan[23:16];
            res.green       = exp_chan[15:8];
            res.blue        = exp_chan[7:0];
            res.alpha       = (exp_bpp == 4) ? alpha_byte : 8'h00;
            res.has_alpha   = (exp_bpp == 4);
            res.last_pixel  = (exp_col + 1 == exp_width) && (exp_row + 1 == exp_height);
            exp_chan = '0;
            exp_lane = '0;
            exp_col  = exp_col + 1;
            if (exp_col == exp_width) begin
              exp_col = '0;
              exp_row = exp_row + 1;
              if (exp_row >= exp_height) begin
                exp_stage = PARSE_IDLE;
              end else begin
                // Pad each row up to a multiple of four bytes.
                exp_pad  = 2'(32'd0 - exp_width * 32'(exp_bpp));
                exp_base = exp_base - exp_width[23:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one byte from a falling edge and return at the falling edge after
  // it was accepted.
  task automatic send_byte(input logic start, input logic [7:0] b);
    bit   emits;
    res_t res;
    res_t typed_res;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(start, b, emits, res);
    if (emits) begin
      typed_res        = '0;
      typed_res.status = typed_status;
      pending_results.push_back(typed_on ? typed_res : res);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected beat has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Send one file: header fields at their offsets, random bytes elsewhere.
  task automatic send_bmp(input logic first_start, input logic [15:0] magic,
                          input logic [31:0] offset, input logic [31:0] width,
                          input logic [31:0] height, input logic [15:0] depth,
                          input int byte_cap);
    int         len;
    int         pitch;
    logic [7:0] b;
    if (byte_cap > 0) begin
      len = byte_cap;
    end else begin
      pitch = (int'(width) * ((depth == DEPTH_32) ? 4 : 3) + 3) / 4 * 4;
      len   = int'(offset) + int'(height) * pitch + $urandom_range(4);
    end
    for (int p = 0; p < len; p++) begin
      b = 8'($urandom_range(255));
      if (p < 2) b = magic[8*p +: 8];
      else if (p >= 10 && p <= 13) b = offset[8*(p-10) +: 8];
      else if (p >= 18 && p <= 21) b = width[8*(p-18) +: 8];
      else if (p >= 22 && p <= 25) b = height[8*(p-22) +: 8];
      else if (p >= 28 && p <= 29) b = depth[8*(p-28) +: 8];
      send_byte((p == 0) ? first_start : 1'b0, b);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Result side: compare every accepted beat with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual tuser %0h tdata %0h tlast %0b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser[1:0]));
        check_field("pixel_index", 32'(want.pixel_index), 32'(m_axis_tdata[23:0]));
        check_field("red", 32'(want.red), 32'(m_axis_tdata[31:24]));
        check_field("green", 32'(want.green), 32'(m_axis_tdata[39:32]));
        check_field("blue", 32'(want.blue), 32'(m_axis_tdata[47:40]));
        check_field("alpha", 32'(want.alpha), 32'(m_axis_tdata[55:48]));
        check_field("has_alpha", 32'(want.has_alpha), 32'(m_axis_tuser[2]));
        check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested so
  // that the output stage fills and the decoder stalls its input.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_request = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          kind;
    int          start_bytes;
    int          w;
    int          h;
    int          pitch;
    int          full_len;
    logic [15:0] magic;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] depth;

    // start, magic, offset, width, height, depth, cap, typed, status
    dir_cases = '{
      // Bytes without a start right after reset are dropped.
      '{1'b0, MAGIC_BM, 32'd54, 32'd1, 32'd1, DEPTH_24, 32'd8, 1'b0, ST_PIXEL},
      // Bad magic; the bytes after the error are dropped as well.
      '{1'b1, 16'h4E42, 32'd54, 32'd1, 32'd1, DEPTH_24, 32'd8, 1'b1, ST_BAD_MAGIC},
      '{1'b1, 16'h4D41, 32'd54, 32'd1, 32'd1, DEPTH_24, 32'd8, 1'b1, ST_BAD_MAGIC},
      '{1'b1, 16'h424D, 32'd54, 32'd1, 32'd1, DEPTH_24, 32'd8, 1'b1, ST_BAD_MAGIC},
      // Unsupported depths, and depth winning over a bad size.
      '{1'b1, MAGIC_BM, 32'd54, 32'd2, 32'd2, 16'd16, 32'd32, 1'b1, ST_BAD_DEPTH},
      '{1'b1, MAGIC_BM, 32'd54, 32'd2, 32'd2, 16'h0118, 32'd32, 1'b1, ST_BAD_DEPTH},
      '{1'b1, MAGIC_BM, 32'd54, 32'd0, 32'd2, 16'd8, 32'd32, 1'b1, ST_BAD_DEPTH},
      // Zero, oversized and negative dimensions, offset below the headers.
      '{1'b1, MAGIC_BM, 32'd54, 32'd0, 32'd2, DEPTH_32, 32'd32, 1'b1, ST_BAD_SIZE},
      '{1'b1, MAGIC_BM, 32'd54, 32'd2, 32'd0, DEPTH_24, 32'd32, 1'b1, ST_BAD_SIZE},
      '{1'b1, MAGIC_BM, 32'd54, 32'd4097, 32'd2, DEPTH_24, 32'd32, 1'b1, ST_BAD_SIZE},
      '{1'b1, MAGIC_BM, 32'd54, 32'd2, 32'd4097, DEPTH_32, 32'd32, 1'b1, ST_BAD_SIZE},
      '{1'b1, MAGIC_BM, 32'd54, 32'hFFFF_FFFF, 32'd2, DEPTH_24, 32'd32, 1'b1, ST_BAD_SIZE},
      '{1'b1, MAGIC_BM, 32'd54, 32'd2, 32'h8000_0000, DEPTH_24, 32'd32, 1'b1, ST_BAD_SIZE},
      '{1'b1, MAGIC_BM, 32'd53, 32'd1, 32'd1, DEPTH_24, 32'd32, 1'b1, ST_BAD_SIZE},
      // Well-formed images with every amount of row padding.
      '{1'b1, MAGIC_BM, 32'd54, 32'd1, 32'd1, DEPTH_24, 32'd0, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd1, 32'd1, DEPTH_32, 32'd0, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd3, 32'd2, DEPTH_24, 32'd0, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd61, 32'd2, 32'd2, DEPTH_32, 32'd0, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd5, 32'd3, DEPTH_24, 32'd0, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd2, 32'd3, DEPTH_24, 32'd0, 1'b0, ST_PIXEL},
      // Restarts inside the header, the skip and the pixel data.
      '{1'b1, MAGIC_BM, 32'd54, 32'd4, 32'd4, DEPTH_24, 32'd20, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd64, 32'd3, 32'd1, DEPTH_32, 32'd40, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd4096, 32'd4096, DEPTH_32, 32'd60, 1'b0, ST_PIXEL},
      // Largest width and largest height, cut short after the first pixels, then a whole 32-bit image.
      '{1'b1, MAGIC_BM, 32'd54, 32'd4096, 32'd1, DEPTH_24, 32'd62, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd1, 32'd4096, DEPTH_24, 32'd62, 1'b0, ST_PIXEL},
      '{1'b1, MAGIC_BM, 32'd54, 32'd7, 32'd2, DEPTH_32, 32'd0, 1'b0, ST_PIXEL}
    };

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase_sel = 0; phase_sel < 3; phase_sel++) begin
      case (phase_sel)
        0: begin send_gap_pct = 18; recv_stall_pct = 68; end
        1: begin send_gap_pct = 68; recv_stall_pct = 18; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase

      if (phase_sel == 0) begin
        foreach (dir_cases[i]) begin
          typed_on     = dir_cases[i].status_typed;
          typed_status = dir_cases[i].status;
          send_bmp(dir_cases[i].first_start, dir_cases[i].magic, dir_cases[i].offset,
                   dir_cases[i].width, dir_cases[i].height, dir_cases[i].depth,
                   int'(dir_cases[i].byte_cap));
        end
        typed_on = 1'b0;
      end

      // Hold the receiver off while the random files start to stream in.
      hold_request = 1'b1;
      start_bytes  = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
        kind   = $urandom_range(99);
        magic  = MAGIC_BM;
        w      = $urandom_range(1, 6);
        h      = $urandom_range(1, 4);
        width  = w;
        height = h;
        depth  = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
        offset = $urandom_range(54, 62);
        if (kind < 60) begin
          send_bmp(1'b1, magic, offset, width, height, depth, 0);
        end else if (kind < 70) begin
          // Cut short; the next file's start restarts parsing.
          pitch    = (w * ((depth == DEPTH_32) ? 4 : 3) + 3) / 4 * 4;
          full_len = int'(offset) + h * pitch;
          send_bmp(1'b1, magic, offset, width, height, depth,
                   $urandom_range(2, full_len - 1));
        end else if (kind < 78) begin
          send_bmp(1'b1, 16'($urandom_range(65535)), offset, width, height, depth, 40);
        end else if (kind < 86) begin
          send_bmp(1'b1, magic, offset, width, height, 16'($urandom_range(65535)), 40);
        end else if (kind < 93) begin
          case ($urandom_range(5))
            0: width  = 0;
            1: height = 0;
            2: width  = $urandom_range(4097, 70000);
            3: height = $urandom_range(4097, 70000);
            4: width  = {1'b1, 31'($urandom)};
            default: offset = $urandom_range(53);
          endcase
          send_bmp(1'b1, magic, offset, width, height, depth, 40);
        end else begin
          // Noise with stray starts.
          for (int n = $urandom_range(10, 40); n > 0; n--)
            send_byte($urandom_range(15) == 0, 8'($urandom_range(255)));
        end
        if ($urandom_range(19) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
